// ===== hdl/accumulator_cpu_with_char_io_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the accumulator CPU checker
// Shared property shapes: same-cycle and next-cycle implication.
// ---------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_WITH_CHAR_IO_ASSERT_SVH
`define ACCUMULATOR_CPU_WITH_CHAR_IO_ASSERT_SVH

// Same-cycle implication, quiet while reset is held
`define ACIO_ASSERT_NOW(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held
`define ACIO_ASSERT_NEXT(label, ck, rstn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acio_pkg.sv =====
// ---------------------------------------------------------------------------
// acio_pkg
// Types and constants of the accumulator CPU with character I/O.
// ---------------------------------------------------------------------------
`default_nettype none

package acio_pkg;

    localparam int WORD_BITS = 16;
    localparam int ADDR_BITS = WORD_BITS - 3;
    localparam int MEM_WORDS = 8192;
    localparam int BYTE_BITS = 8;

    // Memory-mapped character words
    localparam logic [ADDR_BITS-1:0] IN_WORD  = ADDR_BITS'(MEM_WORDS - 2);
    localparam logic [ADDR_BITS-1:0] OUT_WORD = ADDR_BITS'(MEM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] IN_RESET  = WORD_BITS'(10);
    localparam logic [WORD_BITS-1:0] OUT_RESET = '0;

    // Stream layout
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;
    localparam int IN_USER_W   = 1;

    localparam int IN_LDADDR_LSB = 0;
    localparam int IN_LDWORD_LSB = IN_LDADDR_LSB + ADDR_BITS;
    localparam int IN_RXVAL_LSB  = IN_LDWORD_LSB + WORD_BITS;
    localparam int IN_RXBYTE_LSB = IN_RXVAL_LSB + 1;

    localparam int OUT_PAD_W = OUT_TDATA_W - (2 + BYTE_BITS + ADDR_BITS + WORD_BITS);

    // Item kinds carried in tuser
    localparam logic ITEM_RUN  = 1'b0;
    localparam logic ITEM_LOAD = 1'b1;

    typedef enum logic [2:0] {
        OP_GET = 3'd0,
        OP_SET = 3'd1,
        OP_ADD = 3'd2,
        OP_SUB = 3'd3,
        OP_JMP = 3'd4,
        OP_JN  = 3'd5,
        OP_JP  = 3'd6,
        OP_JZ  = 3'd7
    } opc_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEC,
        S_OPR,
        S_LDF
    } state_t;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_IN,
        SEL_OUT
    } io_sel_t;

    // One write and one read port request toward the program memory
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/acio_mem.sv =====
// ---------------------------------------------------------------------------
// acio_mem
// Program and data memory: one write and one registered read per cycle,
// with write-to-read forwarding when both hit the same word.
// ---------------------------------------------------------------------------
`default_nettype none

module acio_mem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  acio_pkg::mem_req_t            req,
    output logic [acio_pkg::WORD_BITS-1:0] rdata
);
    import acio_pkg::*;

    logic [WORD_BITS-1:0] mem [MEM_WORDS];
    logic [WORD_BITS-1:0] q_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_hit_next;
    logic [WORD_BITS-1:0] fwd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            q_reg <= mem[req.raddr];
        end
    end

    // Detect a read of the word being written in the same cycle
    assign fwd_hit_next = req.we && (req.waddr == req.raddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (req.re)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            fwd_data_reg <= req.wdata;
        end
    end

    // Return the fresh word on a collision
    assign rdata = fwd_hit_reg ? fwd_data_reg : q_reg;

endmodule

`default_nettype wire

// ===== hdl/accumulator_cpu_with_char_io.sv =====
// ---------------------------------------------------------------------------
// accumulator_cpu_with_char_io
// 16-bit accumulator machine, 8192-word memory, character input and output
// through two memory-mapped words.
// ---------------------------------------------------------------------------
//
//  channel  | dir | transaction
//  ---------+-----+------------------------------------------------------
//  s_axis   | in  | one item: run a machine cycle or load a program word
//  m_axis   | out | one result per item: rx/tx status, pc, accumulator
//
//  GET, ADD and SUB go through fetch read, operand read and finish; SET and
//  jumps finish in decode, loads in their write step. The single memory read port sets this.
//  The next item is taken in the finish cycle of the current one.
//  The input and output words live in flip-flops and reset to 10 and 0;
//  the rest of memory is not cleared, so no clearing pass follows reset.
//  A stalled m_axis holds the result and the finish cycle waits for it.
//
`default_nettype none

module accumulator_cpu_with_char_io (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // load_address[12:0], load_word[28:13], rx_valid[29], rx_byte[37:30]
    input  logic [acio_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // item_kind[0]: 0 run, 1 load
    input  logic [acio_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rx_taken[0], tx_valid[1], tx_byte[9:2], program_counter[22:10],
    // accumulator[38:23]
    output logic [acio_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import acio_pkg::*;

    state_t               state_reg, state_next;
    logic [ADDR_BITS-1:0] pc_reg, pc_next, pc_post;
    logic [WORD_BITS-1:0] acc_reg, acc_post;
    logic [WORD_BITS-1:0] in_reg, in_next, in_post;
    logic [WORD_BITS-1:0] out_reg, out_next, out_post;
    opc_t                 opc_reg;
    io_sel_t              rd_sel_reg, rd_sel_next;
    logic                 rx_taken_reg;
    logic                 tx_valid_reg;
    logic [BYTE_BITS-1:0] tx_byte_reg;
    logic [ADDR_BITS-1:0] ld_addr_reg;
    logic [WORD_BITS-1:0] ld_word_reg;
    logic                 m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic                 in_load;
    logic [ADDR_BITS-1:0] in_ld_addr;
    logic [WORD_BITS-1:0] in_ld_word;
    logic                 in_rx_valid;
    logic [BYTE_BITS-1:0] in_rx_byte;

    logic [WORD_BITS-1:0] mem_rdata, rd_word;
    opc_t                 dec_opc;
    logic [ADDR_BITS-1:0] dec_addr;
    logic                 acc_neg, acc_zero;
    logic                 slot_free, fin, need_opr, accept, take, emit;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    mem_req_t             req;

    // Unpack the input transaction
    assign in_load     = (s_axis_tuser[0] == ITEM_LOAD);
    assign in_ld_addr  = s_axis_tdata[IN_LDADDR_LSB +: ADDR_BITS];
    assign in_ld_word  = s_axis_tdata[IN_LDWORD_LSB +: WORD_BITS];
    assign in_rx_valid = s_axis_tdata[IN_RXVAL_LSB];
    assign in_rx_byte  = s_axis_tdata[IN_RXBYTE_LSB +: BYTE_BITS];

    // Select the read source: memory or one of the character words
    always_comb
    begin
        case (rd_sel_reg)
            SEL_IN:  rd_word = in_reg;
            SEL_OUT: rd_word = out_reg;
            default: rd_word = mem_rdata;
        endcase
    end

    assign dec_opc   = opc_t'(rd_word[WORD_BITS-1 -: 3]);
    assign dec_addr  = rd_word[ADDR_BITS-1:0];
    assign acc_neg   = acc_reg[WORD_BITS-1];
    assign acc_zero  = (acc_reg == '0);
    assign slot_free = !m_valid_reg || m_axis_tready;

    // Execute and finish the current item
    always_comb
    begin
        fin      = 1'b0;
        need_opr = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = dec_addr;
        wr_data  = acc_reg;
        pc_post  = pc_reg;
        acc_post = acc_reg;
        case (state_reg)
            S_DEC:
            begin
                case (dec_opc)
                    OP_GET, OP_ADD, OP_SUB:
                    begin
                        need_opr = 1'b1;
                    end
                    OP_SET:
                    begin
                        fin   = slot_free;
                        wr_en = slot_free;
                    end
                    OP_JMP:
                    begin
                        fin = slot_free;
                        if (fin)
                        begin
                            pc_post = dec_addr;
                        end
                    end
                    OP_JN:
                    begin
                        fin = slot_free;
                        if (fin && acc_neg)
                        begin
                            pc_post = dec_addr;
                        end
                    end
                    OP_JP:
                    begin
                        fin = slot_free;
                        if (fin && !acc_neg && !acc_zero)
                        begin
                            pc_post = dec_addr;
                        end
                    end
                    default:
                    begin
                        fin = slot_free;
                        if (fin && acc_zero)
                        begin
                            pc_post = dec_addr;
                        end
                    end
                endcase
            end
            S_OPR:
            begin
                fin = slot_free;
                if (fin)
                begin
                    case (opc_reg)
                        OP_GET:  acc_post = rd_word;
                        OP_ADD:  acc_post = acc_reg + rd_word;
                        default: acc_post = acc_reg + ~rd_word + WORD_BITS'(1);
                    endcase
                end
            end
            S_LDF:
            begin
                fin     = slot_free;
                wr_en   = slot_free;
                wr_addr = ld_addr_reg;
                wr_data = ld_word_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Route writes of the character words to their flip-flops
    assign in_post  = (wr_en && wr_addr == IN_WORD) ? wr_data : in_reg;
    assign out_post = (wr_en && wr_addr == OUT_WORD) ? wr_data : out_reg;

    assign s_axis_tready = (state_reg == S_IDLE) || fin;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Character step of a run item, on the post-finish words
    assign take = accept && !in_load && (in_post[BYTE_BITS-1:0] == '0) && in_rx_valid;
    assign emit = accept && !in_load && (out_post[BYTE_BITS-1:0] != '0);

    assign in_next  = take ? {in_post[WORD_BITS-1:BYTE_BITS], in_rx_byte} : in_post;
    assign out_next = emit ? {out_post[WORD_BITS-1:BYTE_BITS], {BYTE_BITS{1'b0}}}
                           : out_post;
    assign pc_next  = (accept && !in_load) ? pc_post + ADDR_BITS'(1) : pc_post;

    // Memory request: fetch on a run accept, operand read in decode
    always_comb
    begin
        req.we    = wr_en && (wr_addr != IN_WORD) && (wr_addr != OUT_WORD);
        req.waddr = wr_addr;
        req.wdata = wr_data;
        req.re    = (accept && !in_load) || need_opr;
        req.raddr = need_opr ? dec_addr : pc_post;
        if (req.raddr == IN_WORD)
        begin
            rd_sel_next = SEL_IN;
        end
        else if (req.raddr == OUT_WORD)
        begin
            rd_sel_next = SEL_OUT;
        end
        else
        begin
            rd_sel_next = SEL_MEM;
        end
    end

    acio_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (mem_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        if (need_opr)
        begin
            state_next = S_OPR;
        end
        else if (fin || state_reg == S_IDLE)
        begin
            if (accept)
            begin
                state_next = in_load ? S_LDF : S_DEC;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pc_reg      <= '0;
            acc_reg     <= '0;
            in_reg      <= IN_RESET;
            out_reg     <= OUT_RESET;
            rd_sel_reg  <= SEL_MEM;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_post;
            in_reg    <= in_next;
            out_reg   <= out_next;
            if (req.re)
            begin
                rd_sel_reg <= rd_sel_next;
            end
            if (fin)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item payload: character status, load request, pending opcode
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rx_taken_reg <= take;
            tx_valid_reg <= emit;
            tx_byte_reg  <= emit ? out_post[BYTE_BITS-1:0] : '0;
            ld_addr_reg  <= in_ld_addr;
            ld_word_reg  <= in_ld_word;
        end
        if (need_opr)
        begin
            opc_reg <= dec_opc;
        end
    end

    // Output register: hold the result until the transaction completes
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            m_data_reg <= {{OUT_PAD_W{1'b0}}, acc_post, pc_post, tx_byte_reg,
                           tx_valid_reg, rx_taken_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire

// ===== hdl/acio_checker.sv =====
// ---------------------------------------------------------------------------
// acio_checker
// Port-level checks of the accumulator CPU result stream, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "accumulator_cpu_with_char_io_assert.svh"

module acio_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [acio_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import acio_pkg::*;

    logic                 res_tx_valid;
    logic [BYTE_BITS-1:0] res_tx_byte;

    assign res_tx_valid = m_axis_tdata[1];
    assign res_tx_byte  = m_axis_tdata[2 +: BYTE_BITS];

    // Hold a stalled result
    `ACIO_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // An emitted character is never zero
    `ACIO_ASSERT_NOW(a_tx_nonzero, clk, rst_n, m_axis_tvalid && res_tx_valid, res_tx_byte != '0, "emitted character is zero")

    // No character shows without an emit
    `ACIO_ASSERT_NOW(a_tx_quiet, clk, rst_n, m_axis_tvalid && !res_tx_valid, res_tx_byte == '0, "character byte without emit")

endmodule

bind accumulator_cpu_with_char_io acio_checker u_acio_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
